// ===== rtl/bise_pkg.sv =====
// shared types, constants and status codes for the back-reference id stream expander
package bise_pkg;

	localparam int HISTORY_DEPTH_DEF = 65536;
	localparam int NUM_IDS = 4096;
	localparam int MAX_RUN = 64;

	localparam int WORD_W = 32;
	localparam int LEN_W = WORD_W - 1;
	localparam int ID_W = 12;
	localparam int CNT_W = 32;
	localparam int RUN_W = $clog2(MAX_RUN + 1);

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD_ID = 2'd1;
	localparam logic [1:0] ST_REJECT = 2'd2;
	localparam logic [1:0] ST_DANGLING = 2'd3;

	typedef struct packed {
		logic [WORD_W-1:0] compressed_word;
		logic end_of_sequence;
	} word_t;

	typedef struct packed {
		logic [ID_W-1:0] symbol_id;
		logic [CNT_W-1:0] occurrence_count;
		logic last_of_run;
		logic [1:0] status;
	} result_t;

	typedef struct packed {
		logic rd_en;
		logic [ID_W-1:0] rd_addr;
		logic wr_en;
		logic [ID_W-1:0] wr_addr;
		logic [CNT_W-1:0] wr_data;
	} cnt_req_t;

endpackage

// ===== rtl/bise_hist_mem.sv =====
// history ring memory of expanded ids, one write and one registered read port
module bise_hist_mem import bise_pkg::*; #(
	parameter int DEPTH = HISTORY_DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input logic clk,
	input logic rd_en,
	input logic [AW-1:0] rd_addr,
	output logic [ID_W-1:0] rdata,
	input logic wr_en,
	input logic [AW-1:0] wr_addr,
	input logic [ID_W-1:0] wr_data
);

	logic [ID_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/bise_count_mem.sv =====
// occurrence count memory with a clearing sweep after reset
module bise_count_mem import bise_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cnt_req_t req,
	output logic [CNT_W-1:0] rdata,
	output logic busy
);

	logic [CNT_W-1:0] mem [NUM_IDS];
	logic [ID_W-1:0] clr_addr_q;
	logic busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == ID_W'(NUM_IDS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rdata <= mem[req.rd_addr];
		end
	end

	assign busy = busy_q;

endmodule

// ===== rtl/backref_id_stream_expander.sv =====
// top level: word stream decoder and copy sequencer around history and count memories
//
//  channel  dir  handshake            payload
//  word     in   word_valid/stall     word_t   (compressed_word, end_of_sequence)
//  result   out  result_valid/stall   result_t (symbol_id, occurrence_count,
//                                               last_of_run, status)
//
// a literal is a count read then a count write back; a header is held in idle; an
// error passes the error state; a copy does a history read, a count read and a count
// write back in turn for each copied id. after reset the count memory is swept to zero
// over all 4096 ids; word_stall is high during the sweep.
// a result waits in the output register; a stall there holds the sequencer only
// when the next result is ready to be loaded.
module backref_id_stream_expander import bise_pkg::*; #(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic word_valid,
	output logic word_stall,
	input word_t word,
	output logic result_valid,
	input logic result_stall,
	output result_t result
);

	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam int AW1 = AW + 1;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_ERR = 3'd2;
	localparam logic [2:0] S_HRD = 3'd3;
	localparam logic [2:0] S_HWB = 3'd4;
	localparam logic [2:0] S_CUP = 3'd5;

	logic [2:0] state_q;
	logic awaiting_q;
	logic [LEN_W-1:0] held_len_q;
	logic [WORD_W-1:0] pos_q;
	logic [AW-1:0] wp_q;
	logic [AW-1:0] src_q;
	logic [RUN_W-1:0] rem_q;
	logic [ID_W-1:0] id_q;
	logic eos_q;
	logic [1:0] err_q;
	result_t out_q;
	logic out_valid_q;

	logic accept;
	logic out_free;
	logic [WORD_W-1:0] w;
	logic [WORD_W-1:0] back_dist;
	logic [AW:0] dist_n;
	logic [AW:0] wp_ext;
	logic [AW:0] src_ext;
	logic len_big;
	logic len_zero;
	logic win_bad;
	logic lit_ok;
	logic hist_wr;
	logic [AW-1:0] wp_next;
	logic [AW-1:0] src_next;
	logic [ID_W-1:0] hist_rdata;
	logic [CNT_W-1:0] cnt_rdata;
	logic [CNT_W-1:0] cnt_new;
	logic cnt_busy;
	cnt_req_t cnt_req;

	assign w = word.compressed_word;
	assign accept = word_valid && (state_q == S_IDLE);
	assign word_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !result_stall;

	// copy window check and source address in the ring
	assign back_dist = pos_q - w;
	assign dist_n = back_dist[AW:0];
	assign wp_ext = {1'b0, wp_q};
	assign src_ext = (dist_n <= wp_ext) ? (wp_ext - dist_n)
		: (wp_ext + AW1'(HISTORY_DEPTH) - dist_n);
	assign len_big = held_len_q > LEN_W'(MAX_RUN);
	assign len_zero = (held_len_q == '0);
	assign win_bad = (w >= pos_q) || (back_dist > WORD_W'(HISTORY_DEPTH));
	assign lit_ok = accept && !awaiting_q && !w[WORD_W-1] && (w < WORD_W'(NUM_IDS));

	assign hist_wr = lit_ok || (state_q == S_HWB);
	assign wp_next = (pos_q == '1 || wp_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + 1'b1;
	assign src_next = (src_q == AW'(HISTORY_DEPTH - 1)) ? '0 : src_q + 1'b1;
	assign cnt_new = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + 1'b1;

	always_comb begin
		cnt_req.rd_en = hist_wr;
		cnt_req.rd_addr = (state_q == S_HWB) ? hist_rdata : w[ID_W-1:0];
		cnt_req.wr_en = (state_q == S_CUP) && out_free;
		cnt_req.wr_addr = id_q;
		cnt_req.wr_data = cnt_new;
	end

	bise_hist_mem #(
		.DEPTH(HISTORY_DEPTH)
	) u_hist (
		.clk(clk),
		.rd_en(state_q == S_HRD),
		.rd_addr(src_q),
		.rdata(hist_rdata),
		.wr_en(hist_wr),
		.wr_addr(wp_q),
		.wr_data((state_q == S_HWB) ? hist_rdata : w[ID_W-1:0])
	);

	bise_count_mem u_cnt (
		.clk(clk),
		.arst_n(arst_n),
		.req(cnt_req),
		.rdata(cnt_rdata),
		.busy(cnt_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			awaiting_q <= 1'b0;
			held_len_q <= '0;
			pos_q <= '0;
			wp_q <= '0;
			src_q <= '0;
			rem_q <= '0;
			id_q <= '0;
			eos_q <= 1'b0;
			err_q <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= 1'b0;
			end
			if (hist_wr) begin
				pos_q <= pos_q + 1'b1;
				wp_q <= wp_next;
			end
			case (state_q)
				S_CLEAR: begin
					if (!cnt_busy) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						eos_q <= word.end_of_sequence;
						if (awaiting_q) begin
							awaiting_q <= 1'b0;
							if (len_big || (!len_zero && win_bad)) begin
								err_q <= ST_REJECT;
								state_q <= S_ERR;
							end else if (len_zero) begin
								if (word.end_of_sequence) begin
									pos_q <= '0;
									wp_q <= '0;
								end
							end else begin
								src_q <= src_ext[AW-1:0];
								rem_q <= RUN_W'(held_len_q);
								state_q <= S_HRD;
							end
						end else if (w[WORD_W-1]) begin
							if (word.end_of_sequence) begin
								err_q <= ST_DANGLING;
								state_q <= S_ERR;
							end else begin
								held_len_q <= w[LEN_W-1:0];
								awaiting_q <= 1'b1;
							end
						end else if (!lit_ok) begin
							err_q <= ST_BAD_ID;
							state_q <= S_ERR;
						end else begin
							id_q <= w[ID_W-1:0];
							rem_q <= RUN_W'(1);
							state_q <= S_CUP;
						end
					end
				end
				S_ERR: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
						if (eos_q) begin
							pos_q <= '0;
							wp_q <= '0;
						end
					end
				end
				S_HRD: begin
					state_q <= S_HWB;
				end
				S_HWB: begin
					id_q <= hist_rdata;
					state_q <= S_CUP;
				end
				S_CUP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						rem_q <= rem_q - 1'b1;
						src_q <= src_next;
						if (rem_q == RUN_W'(1)) begin
							state_q <= S_IDLE;
							if (eos_q) begin
								pos_q <= '0;
								wp_q <= '0;
							end
						end else begin
							state_q <= S_HRD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (state_q == S_ERR && out_free) begin
			out_q.symbol_id <= '0;
			out_q.occurrence_count <= '0;
			out_q.last_of_run <= 1'b1;
			out_q.status <= err_q;
		end else if (state_q == S_CUP && out_free) begin
			out_q.symbol_id <= id_q;
			out_q.occurrence_count <= cnt_new;
			out_q.last_of_run <= (rem_q == RUN_W'(1));
			out_q.status <= ST_OK;
		end
	end

	assign result_valid = out_valid_q;
	assign result = out_q;

`ifndef SYNTHESIS
	a_await_idle: assert property (@(posedge clk) disable iff (!arst_n)
		awaiting_q |-> (state_q == S_IDLE))
		else $error("pending run header outside idle");

	a_copy_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HRD || state_q == S_HWB || state_q == S_CUP) |-> (rem_q != '0))
		else $error("copy step with no remaining ids");

	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CUP && out_free) |=> out_valid_q)
		else $error("count write back without a result");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status != ST_OK) |->
		(out_q.symbol_id == '0 && out_q.occurrence_count == '0 && out_q.last_of_run))
		else $error("error result carries data");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_busy |-> (!cnt_req.wr_en && !hist_wr && !out_valid_q))
		else $error("activity during count clearing");
`endif

endmodule
